>>> hw/rtl/hec_pkg.sv
// ============================================================================
// hec_pkg
// Types, constants and bit-mapping functions for the Hamming encoder and
// single-error corrector.
// ============================================================================
package hec_pkg;

    localparam int WORD_W         = 63;
    localparam int SYN_W          = 6;
    localparam int CFG_W          = 3;
    localparam int MIN_CHECK_BITS = 2;
    localparam int MAX_CHECK_BITS = 6;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [SYN_W-1:0]  syn_t;
    typedef logic [CFG_W-1:0]  cfg_t;

    // Operation codes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam cfg_t CHECK_BITS_RESET = cfg_t'(MAX_CHECK_BITS);

    // Clamp the programmed check count to the supported range
    function automatic cfg_t check_count(input cfg_t cfg);
        cfg_t m;
        m = cfg;
        if (cfg < cfg_t'(MIN_CHECK_BITS)) begin
            m = cfg_t'(MIN_CHECK_BITS);
        end else if (cfg > cfg_t'(MAX_CHECK_BITS)) begin
            m = cfg_t'(MAX_CHECK_BITS);
        end
        return m;
    endfunction

    // Mask of the n = 2^m - 1 codeword positions
    function automatic word_t code_mask(input cfg_t m);
        word_t r;
        case (m)
            3'd2:    r = word_t'(63'h7);
            3'd3:    r = word_t'(63'h7F);
            3'd4:    r = word_t'(63'h7FFF);
            3'd5:    r = word_t'(63'h7FFF_FFFF);
            default: r = '1;
        endcase
        return r;
    endfunction

    // Mask of the k = n - m data bits
    function automatic word_t data_mask(input cfg_t m);
        word_t r;
        case (m)
            3'd2:    r = word_t'(63'h1);
            3'd3:    r = word_t'(63'hF);
            3'd4:    r = word_t'(63'h7FF);
            3'd5:    r = word_t'(63'h3FF_FFFF);
            default: r = word_t'(63'h1FF_FFFF_FFFF_FFFF);
        endcase
        return r;
    endfunction

    function automatic logic is_pow2(input int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    // Spread data bits over the non-power-of-two positions in ascending order;
    // the mapping is fixed wiring and does not depend on the code length
    function automatic word_t data_scatter(input word_t data);
        word_t r;
        int    d;
        r = '0;
        d = 0;
        for (int p = 1; p <= WORD_W; p++) begin
            if (!is_pow2(p)) begin
                r[p-1] = data[d];
                d++;
            end
        end
        return r;
    endfunction

    // Positions whose index has bit j set
    function automatic word_t pos_mask(input int j);
        word_t r;
        r = '0;
        for (int p = 1; p <= WORD_W; p++) begin
            r[p-1] = ((p >> j) & 1) != 0;
        end
        return r;
    endfunction

    // Put check bit j at position 2^j
    function automatic word_t place_checks(input syn_t par);
        word_t r;
        r = '0;
        for (int j = 0; j < SYN_W; j++) begin
            r[(1 << j) - 1] = par[j];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/hamming_encode_correct_top.sv
// ============================================================================
// hamming_encode_correct_top
// Hamming (2^m-1, 2^m-1-m) encoder and single-error corrector.
// ============================================================================
// Usage:
//   Input channel s_*: s_opcode selects encode (data bits in s_payload, bit
//   l-1 is info bit l) or check/correct (received codeword in s_payload).
//   Result channel m_*: m_word carries the codeword or corrected word,
//   m_syndrome the error position (0 if none, always 0 when encoding), and
//   m_corrected flags a flipped bit.
//   cfg_wr_en/cfg_wr_data write the check count m (2..6, values outside are
//   clamped); write it only while no item is in flight.
// Timing:
//   An accepted item sits in the input register; one XOR-tree pass feeds the
//   result register, which drives m_valid and the result. Throughput is one
//   item per cycle while the receiver does not stall.
//   s_ready follows m_ready through the two-stage pipeline, so a stalled
//   receiver holds the result and, once the input stage is full, stops
//   acceptance; bubbles are filled as soon as they appear.
// Reset:
//   aresetn (synchronous, active low) empties both stages and sets m to 6.
// ============================================================================
module hamming_encode_correct_top
    import hec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  cfg_t        cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  word_t       s_payload,

    output logic        m_valid,
    input  logic        m_ready,
    output word_t       m_word,
    output syn_t        m_syndrome,
    output logic        m_corrected
);

    cfg_t  check_bits_reg;

    logic  s1_valid_reg;
    logic  s1_opcode_reg;
    word_t s1_payload_reg;

    logic  out_valid_reg;
    word_t out_word_reg;
    syn_t  out_syn_reg;
    logic  out_corr_reg;

    logic  out_adv;
    logic  s1_adv;

    cfg_t  m_eff;
    word_t base_word;
    syn_t  par;
    word_t flip;
    word_t word_next;
    syn_t  syn_next;
    logic  corr_next;

    // Pipeline flow control
    assign out_adv = !out_valid_reg || m_ready;
    assign s1_adv  = !s1_valid_reg || out_adv;
    assign s_ready = s1_adv;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_bits_reg <= CHECK_BITS_RESET;
        end else if (cfg_wr_en) begin
            check_bits_reg <= cfg_wr_data;
        end
    end

    // Input stage: capture an item whenever the stage frees up
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s_valid) begin
            s1_opcode_reg  <= s_opcode;
            s1_payload_reg <= s_payload;
        end
    end

    // Encode/correct: one parity tree per check bit over the aligned word
    always_comb begin
        m_eff = check_count(check_bits_reg);

        if (s1_opcode_reg == OP_DECODE) begin
            base_word = s1_payload_reg & code_mask(m_eff);
        end else begin
            base_word = data_scatter(s1_payload_reg & data_mask(m_eff));
        end

        for (int j = 0; j < SYN_W; j++) begin
            par[j] = ^(base_word & pos_mask(j));
        end

        flip = (par != '0) ? (word_t'(1) << (par - syn_t'(1))) : '0;

        if (s1_opcode_reg == OP_DECODE) begin
            word_next = base_word ^ flip;
            syn_next  = par;
            corr_next = (par != '0);
        end else begin
            word_next = base_word | place_checks(par);
            syn_next  = '0;
            corr_next = 1'b0;
        end
    end

    // Result stage: hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && s1_valid_reg) begin
            out_word_reg <= word_next;
            out_syn_reg  <= syn_next;
            out_corr_reg <= corr_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_word      = out_word_reg;
    assign m_syndrome  = out_syn_reg;
    assign m_corrected = out_corr_reg;

endmodule

>>> hw/rtl/hec_checker.sv
// ============================================================================
// hec_checker
// Port-level checks for the Hamming encoder/corrector, bound to the top level.
// ============================================================================
module hec_checker
    import hec_pkg::*;
(
    input logic  aclk,
    input logic  aresetn,
    input logic  s_ready,
    input logic  m_valid,
    input logic  m_ready,
    input word_t m_word,
    input syn_t  m_syndrome,
    input logic  m_corrected
);

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word) && $stable(m_syndrome)
                                && $stable(m_corrected))
        else $error("result changed while stalled");

    // Flag a correction exactly when the syndrome names a position
    a_corr_syn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_corrected == (m_syndrome != '0)))
        else $error("corrected flag disagrees with syndrome");

    // Drop all results out of reset
    a_reset_empty: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // Accept right after reset
    a_reset_ready: assert property (@(posedge aclk)
        $rose(aresetn) |-> s_ready)
        else $error("not ready right after reset");

endmodule

bind hamming_encode_correct_top hec_checker u_hec_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_word      (m_word),
    .m_syndrome  (m_syndrome),
    .m_corrected (m_corrected)
);
